@@ design/variable_step_rc_lowpass_defines.svh @@
// Assertion macros for the variable-step RC low-pass filter.
// Expects clk and rst_n in the scope of each use.
`ifndef VARIABLE_STEP_RC_LOWPASS_DEFINES_SVH
`define VARIABLE_STEP_RC_LOWPASS_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define VSRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that pre at one edge is followed by post at the next.
`define VSRC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/vsrc_pkg.sv @@
// Shared types and constants of the variable-step RC low-pass filter.
// No dependencies.
package vsrc_pkg;

    // round(2*pi*2^16)
    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
    // 1000 ms in Q16
    localparam logic [25:0] DEN_BASE   = 26'd65536000;
    localparam logic [31:0] MAX_GAP_MS = 32'd1000;
    // Word index of the cutoff register
    localparam logic        CUTOFF_IDX = 1'b0;

    typedef struct packed {
        logic signed [15:0] sample;
        logic        [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               reset_integral;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic mac;
        logic add;
        logic load_out;
    } cmd_t;

endpackage

@@ design/variable_step_rc_lowpass.sv @@
// Top level of the variable-step RC low-pass filter: APB register,
// sequencer and datapath. Depends on vsrc_pkg, vsrc_ctrl and vsrc_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries a signed sample
//   and a millisecond timestamp; a transfer happens when in_valid is high
//   and in_stall is low. Output channel (out_valid / out_stall / out_item)
//   returns one filtered value and a reset_integral flag per input.
//   The gain w*dt/(1000+w*dt) is worked out per item by a restoring
//   divider that yields one quotient bit a cycle.
//   One item is in work at a time: in_stall stays high from the input
//   transfer until the result is loaded into the output register.
//   The cutoff register (cutoff_hz, byte address 0) is written through the
//   APB port; pready is always high. The user must write it only while the
//   block is idle; the block itself does not enforce this.
//   Reset clears the cutoff, the stored timestamp and output, and the
//   first-item mark, and drops out_valid.
//   A stalled result holds in the output register; the next item may be
//   taken meanwhile and waits at its last step until the register frees.
module variable_step_rc_lowpass #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  vsrc_pkg::in_item_t  in_item,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output vsrc_pkg::out_item_t out_item
);

    logic [7:0]     cutoff_reg;
    logic           cfg_write;
    vsrc_pkg::cmd_t cmd;

    // Register write on the access phase; upper word is outside the map
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == vsrc_pkg::CUTOFF_IDX);
    assign prdata    = (paddr[2] == vsrc_pkg::CUTOFF_IDX) ? 32'(cutoff_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cutoff_reg <= '0;
        else if (cfg_write)
            cutoff_reg <= pwdata[7:0];
    end

    // Sequence the multiply, divide and accumulate steps
    vsrc_ctrl #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd)
    );

    // Hold filter state and compute the gain and output
    vsrc_dp #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cutoff_hz(cutoff_reg),
        .in_item  (in_item),
        .cmd      (cmd),
        .out_item (out_item)
    );

endmodule

@@ design/vsrc_ctrl.sv @@
// Sequencer of the variable-step RC low-pass filter.
// Depends on vsrc_pkg and variable_step_rc_lowpass_defines.svh.
`include "variable_step_rc_lowpass_defines.svh"

module vsrc_ctrl #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output vsrc_pkg::cmd_t cmd
);

    localparam int CntW = $clog2(GAIN_FRACTION_BITS);
    localparam logic [CntW-1:0] LastStep = CntW'(GAIN_FRACTION_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIVI,
        S_DIV,
        S_MAC,
        S_ADD,
        S_FIN
    } state_t;

    state_t          state_reg;
    logic [CntW-1:0] cnt_reg;
    logic            out_valid_reg;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = in_valid && (state_reg == S_IDLE);
        cmd.mul1     = (state_reg == S_MUL1);
        cmd.mul2     = (state_reg == S_MUL2);
        cmd.div_init = (state_reg == S_DIVI);
        cmd.div_step = (state_reg == S_DIV);
        cmd.mac      = (state_reg == S_MAC);
        cmd.add      = (state_reg == S_ADD);
        cmd.load_out = (state_reg == S_FIN) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_MUL1;
                end
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_DIVI;
                S_DIVI:
                begin
                    cnt_reg   <= LastStep;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_MAC;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                S_MAC: state_reg <= S_ADD;
                S_ADD: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            // Load on finish, drop after the transfer
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    `VSRC_ASSERT_NEXT(a_accept_starts, cmd.accept, state_reg == S_MUL1, "accept did not start work")
    `VSRC_ASSERT_NEXT(a_div_ends, (state_reg == S_DIV) && (cnt_reg == '0), state_reg == S_MAC, "divide overran")
    `VSRC_ASSERT(a_valid_from_fin, $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN), "result without finish")

endmodule

@@ design/vsrc_dp.sv @@
// Datapath of the variable-step RC low-pass filter: gain multiply,
// restoring divide, multiply-accumulate and truncation.
// Depends on vsrc_pkg and variable_step_rc_lowpass_defines.svh.
`include "variable_step_rc_lowpass_defines.svh"

module vsrc_dp #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          cutoff_hz,
    input  vsrc_pkg::in_item_t  in_item,
    input  vsrc_pkg::cmd_t      cmd,
    output vsrc_pkg::out_item_t out_item
);

    localparam int F   = GAIN_FRACTION_BITS;
    localparam int KW  = 27;        // cutoff * 2pi
    localparam int WW  = 37;        // w * dt in Q16
    localparam int RW  = 38;        // divisor and remainder
    localparam int PW  = F + 18;    // alpha * difference
    localparam int AW  = F + 19;    // accumulator
    localparam logic [AW-1:0] RoundMask = (AW'(1) << F) - AW'(1);

    // Filter state
    logic        [31:0] last_time_reg;
    logic               seen_reg;
    logic signed [15:0] last_output_reg;

    // Per-item payload
    logic signed [15:0]   x_reg;
    logic        [9:0]    dt_reg;
    logic                 rst_flag_reg;
    logic        [KW-1:0] k_reg;
    logic        [RW-1:0] rem_reg;
    logic        [RW-1:0] den_reg;
    logic        [F-1:0]  q_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    vsrc_pkg::out_item_t  out_reg;

    logic        [31:0]   dt_raw;
    logic                 gap;
    logic        [RW:0]   rem_sh;
    logic        [RW:0]   rem_sub;
    logic                 fits;
    logic signed [16:0]   diff;
    logic signed [PW-1:0] mac;
    logic signed [AW-1:0] prev_sh;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] biased;
    logic signed [15:0]   y;

    assign dt_raw  = in_item.now_ms - last_time_reg;
    assign gap     = !seen_reg || (dt_raw > vsrc_pkg::MAX_GAP_MS);

    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    assign diff     = 17'(x_reg) - 17'(last_output_reg);
    assign mac      = $signed({1'b0, q_reg}) * diff;
    assign prev_sh  = AW'(last_output_reg) <<< F;
    assign acc_next = prev_sh + AW'(prod_reg);

    // Bias negative values so the arithmetic shift truncates toward zero
    assign biased = acc_reg + (acc_reg[AW-1] ? $signed(RoundMask) : $signed(AW'(0)));
    assign y      = biased[F+15:F];

    assign out_item = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg   <= '0;
            seen_reg        <= 1'b0;
            last_output_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_time_reg <= in_item.now_ms;
                seen_reg      <= 1'b1;
            end
            if (cmd.load_out)
                last_output_reg <= y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg        <= in_item.sample;
            dt_reg       <= gap ? 10'd0 : dt_raw[9:0];
            rst_flag_reg <= gap;
        end
        if (cmd.mul1)
            k_reg <= KW'(cutoff_hz) * KW'(vsrc_pkg::TWO_PI_Q16);
        if (cmd.mul2)
            rem_reg <= RW'(WW'(k_reg) * WW'(dt_reg));
        if (cmd.div_init)
        begin
            den_reg <= RW'(vsrc_pkg::DEN_BASE) + rem_reg;
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= fits ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
            q_reg   <= {q_reg[F-2:0], fits};
        end
        if (cmd.mac)
            prod_reg <= mac;
        if (cmd.add)
            acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            out_reg.filtered       <= y;
            out_reg.reset_integral <= rst_flag_reg;
        end
    end

    `VSRC_ASSERT(a_between, cmd.load_out |-> (((y >= last_output_reg) && (y <= x_reg)) || ((y <= last_output_reg) && (y >= x_reg))), "output outside prev and sample")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the variable-step RC low-pass filter.
// Depends on vsrc_pkg and variable_step_rc_lowpass; predicts each transfer
// with its own fixed-point gain model and drives APB plus both channels.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = FRAC + 8;
    localparam logic [2:0] CUTOFF_ADDR = {vsrc_pkg::CUTOFF_IDX, 2'b00};

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    vsrc_pkg::in_item_t   in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    vsrc_pkg::out_item_t  out_item;

    // Filter state as the testbench sees it
    logic [7:0]         filt_cutoff = '0;
    logic signed [15:0] filt_last_out = '0;
    logic [31:0]        filt_last_ms = '0;
    logic               filt_primed = 1'b0;

    vsrc_pkg::out_item_t expected_outputs[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_asked = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    logic [31:0] stamp = '0;

    variable_step_rc_lowpass #(
        .GAIN_FRACTION_BITS(FRAC)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Advance the filter by one sample: gain from elapsed time, then blend
    // toward the sample with truncation toward zero.
    function automatic vsrc_pkg::out_item_t predict_filter(vsrc_pkg::in_item_t item);
        logic [31:0] dt;
        logic        gap_reset;
        logic [63:0] wdt;
        logic [63:0] den;
        longint      alpha;
        longint      prev;
        longint      x;
        longint      acc;
        longint      y;
        vsrc_pkg::out_item_t res;
        dt = item.now_ms - filt_last_ms;
        gap_reset = !filt_primed || (dt > vsrc_pkg::MAX_GAP_MS);
        // First transfer or a gap over a second: hold the output
        if (gap_reset)
            dt = '0;
        filt_last_ms = item.now_ms;
        filt_primed = 1'b1;
        wdt = {56'd0, filt_cutoff} * {45'd0, vsrc_pkg::TWO_PI_Q16} * {32'd0, dt};
        den = {38'd0, vsrc_pkg::DEN_BASE} + wdt;
        alpha = (wdt << FRAC) / den;
        prev = longint'(filt_last_out);
        x = longint'($signed(item.sample));
        acc = (prev <<< FRAC) + alpha * (x - prev);
        if (acc < 0)
            y = -((-acc) >>> FRAC);
        else
            y = acc >>> FRAC;
        filt_last_out = y[15:0];
        res.filtered = y[15:0];
        res.reset_integral = gap_reset;
        return res;
    endfunction

    // Offer one sample, idling first at the current rate, and record the
    // expected result once the transfer happens.
    task automatic send_sample(logic signed [15:0] sample, logic [31:0] now_ms);
        vsrc_pkg::in_item_t item;
        item.sample = sample;
        item.now_ms = now_ms;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do
            @(posedge clk);
        while (in_stall);
        expected_outputs.push_back(predict_filter(item));
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the cutoff through APB and read it back; call only when idle.
    task automatic write_cutoff(logic [7:0] hz);
        logic [31:0] readback;
        filt_cutoff = hz;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CUTOFF_ADDR;
        pwdata <= {24'd0, hz};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[7:0] !== hz)
        begin
            $error("cutoff_hz readback: expected %0d, got %0d", hz, readback[7:0]);
            mismatch_count++;
        end
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly in-window steps, some zero or tiny, some at or past the gap
    // limit, and now and then a jump anywhere on the clock.
    function automatic logic [31:0] next_stamp(logic [31:0] t);
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return t + $urandom_range(1001, 5000);
            2: return t + 32'd1000;
            3, 4, 5: return t + $urandom_range(0, 10);
            default: return t + $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic logic [7:0] pick_cutoff();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Receiver: stall at random, or hold off for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Compare each output transfer against the oldest expectation
    always @(posedge clk)
    begin
        vsrc_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected result: filtered %0d reset_integral %0b",
                       out_item.filtered, out_item.reset_integral);
                mismatch_count++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (out_item.filtered !== want.filtered)
                begin
                    $error("filtered: expected %0d, got %0d",
                           want.filtered, out_item.filtered);
                    mismatch_count++;
                end
                if (out_item.reset_integral !== want.reset_integral)
                begin
                    $error("reset_integral: expected %0b, got %0b",
                           want.reset_integral, out_item.reset_integral);
                    mismatch_count++;
                end
            end
        end
    end

    // First transfer after reset flags a reset and holds; cutoff is still zero
    task automatic test_first_item();
        send_sample(16'sh7FFF, 32'd0);
        send_sample(16'sh8000, 32'd0);
        send_sample(16'sd100, 32'd500);
        stamp = 32'd500;
        drain_results();
    endtask

    // Highest and lowest cutoff, gap boundary, timestamp wrap, zero cutoff
    task automatic test_gain_extremes();
        write_cutoff(8'd255);
        stamp += 32'd1000;
        send_sample(16'sh7FFF, stamp);
        stamp += 32'd1001;
        send_sample(16'sh8000, stamp);
        send_sample(16'sh8000, stamp);
        stamp += 32'd1000;
        send_sample(16'sh8000, stamp);
        stamp += 32'd1;
        send_sample(16'sh7FFF, stamp);
        stamp = 32'hFFFF_FF00;
        send_sample(16'sh0000, stamp);
        stamp = 32'h0000_0010;
        send_sample(16'shFFFF, stamp);
        stamp += 32'd3;
        send_sample(16'sh0001, stamp);
        drain_results();

        write_cutoff(8'd1);
        stamp += 32'd1;
        send_sample(16'sh7FFF, stamp);
        stamp += 32'd1000;
        send_sample(16'sh8000, stamp);
        stamp += 32'd250;
        send_sample(16'sd12345, stamp);
        stamp += 32'd999;
        send_sample(-16'sd12345, stamp);
        drain_results();

        write_cutoff(8'd0);
        stamp += 32'd500;
        send_sample(16'sh7FFF, stamp);
        stamp += 32'd1000;
        send_sample(16'sh8000, stamp);
        drain_results();
    endtask

    // Random traffic at the given idle rates; retune the cutoff every 100
    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                drain_results();
                write_cutoff(pick_cutoff());
            end
            stamp = next_stamp(stamp);
            send_sample(pick_sample(), stamp);
        end
        drain_results();
    endtask

    // Hold the output off while the sender keeps pushing so the block backs
    // up and stalls its input, then pause until everything has drained.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cutoff(8'd200);
        hold_asked++;
        for (int i = 0; i < 40; i++)
        begin
            stamp = next_stamp(stamp);
            send_sample(pick_sample(), stamp);
        end
        drain_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_first_item();
        test_gain_extremes();
        test_random_traffic(29, 53, 320);
        test_random_traffic(53, 29, 320);
        test_random_traffic(0, 0, 320);
        test_output_backpressure();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Bound the run in case a handshake never completes
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ variable_step_rc_lowpass.f @@
+incdir+design
design/vsrc_pkg.sv
design/vsrc_ctrl.sv
design/vsrc_dp.sv
design/variable_step_rc_lowpass.sv
tb/tb.sv
